/* rtl/ptpom_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpom_pkg - shared types and constants of the PTP offset running mean
// Field widths, stream packing, message kinds and fixed-point settings.
// ----------------------------------------------------------------------------
package ptpom_pkg;

  // Fixed-point and counter settings
  localparam int FRAC_BITS  = 16;
  localparam int COUNT_BITS = 32;

  // Field widths
  localparam int MODE_W     = 2;
  localparam int CAP_W      = 63;
  localparam int SEC_W      = 48;
  localparam int NSEC_W     = 30;
  localparam int ID_W       = 64;
  localparam int MEAN_W     = 64;
  localparam int OUT_MEAN_W = 48;
  localparam int MAG_W      = 48;
  localparam int WIDE_W     = 64;

  // Serial multiplier: seconds below the limit fit in this many bits
  localparam int MUL_BITS  = 34;
  localparam int MUL_CNT_W = $clog2(MUL_BITS);

  // Serial divider: one quotient bit per cycle
  localparam int DIV_W     = COUNT_BITS + 1;
  localparam int DIV_STEPS = WIDE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [WIDE_W-1:0] NS_PER_S      = WIDE_W'(64'd1_000_000_000);
  localparam logic [SEC_W-1:0]  SECONDS_LIMIT = SEC_W'(64'd10_000_000_000);
  localparam logic [MAG_W-1:0]  DIFF_LIMIT    = MAG_W'(64'h0000_8000_0000_0000);
  localparam logic [MEAN_W-1:0] FRAC_MASK     = (MEAN_W'(1) << FRAC_BITS) - MEAN_W'(1);
  localparam logic [MEAN_W-1:0] POS_MAX       = {1'b0, {(MEAN_W-1){1'b1}}};

  // Input stream packing (tdata, lowest bit first)
  localparam int IN_CAP_LO  = 0;
  localparam int IN_SEC_LO  = IN_CAP_LO + CAP_W;
  localparam int IN_NSEC_LO = IN_SEC_LO + SEC_W;
  localparam int IN_ID_LO   = IN_NSEC_LO + NSEC_W;
  localparam int IN_BITS    = IN_ID_LO + ID_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Result stream packing (tdata, lowest bit first)
  localparam int OUT_INFO_BIT  = 0;
  localparam int OUT_MEAN_LO   = 1;
  localparam int OUT_KNOWN_BIT = OUT_MEAN_LO + OUT_MEAN_W;
  localparam int OUT_TWO_BIT   = OUT_KNOWN_BIT + 1;
  localparam int OUT_MVAL_BIT  = OUT_TWO_BIT + 1;
  localparam int OUT_ID_LO     = OUT_MVAL_BIT + 1;
  localparam int OUT_BITS      = OUT_ID_LO + ID_W;
  localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_SYNC     = 2'd0,
    MODE_FOLLOWUP = 2'd1,
    MODE_ANNOUNCE = 2'd2,
    MODE_OTHER    = 2'd3
  } mode_t;

endpackage

/* rtl/ptpom_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpom_mul - bit-serial seconds to nanoseconds converter
// Forms seconds * 10^9 + nanoseconds, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ptpom_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ptpom_pkg::MUL_BITS-1:0]      seconds,
  input  logic [ptpom_pkg::NSEC_W-1:0]        nanoseconds,
  output logic                                done,
  output logic [ptpom_pkg::WIDE_W-1:0]        product
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [ptpom_pkg::MUL_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ptpom_pkg::MUL_BITS-1:0]     mplr_r, mplr_nxt;
  logic [ptpom_pkg::WIDE_W-1:0]       mcand_r, mcand_nxt;
  logic [ptpom_pkg::WIDE_W-1:0]       acc_r, acc_nxt;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mplr_nxt  = mplr_r;
    mcand_nxt = mcand_r;
    acc_nxt   = acc_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = ptpom_pkg::MUL_CNT_W'(ptpom_pkg::MUL_BITS - 1);
      mplr_nxt  = seconds;
      mcand_nxt = ptpom_pkg::NS_PER_S;
      acc_nxt   = ptpom_pkg::WIDE_W'(nanoseconds);
    end else if (busy_r) begin
      // add the shifted constant where the seconds bit is set, then advance
      if (mplr_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mplr_nxt  = mplr_r >> 1;
      mcand_nxt = mcand_r << 1;
      cnt_nxt   = cnt_r - ptpom_pkg::MUL_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    mplr_r  <= mplr_nxt;
    mcand_r <= mcand_nxt;
    acc_r   <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

/* rtl/ptpom_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpom_div - bit-serial restoring divider
// Unsigned 64-bit dividend over the sample count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptpom_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [ptpom_pkg::WIDE_W-1:0]       dividend,
  input  logic [ptpom_pkg::DIV_W-1:0]        divisor,
  output logic                               done,
  output logic [ptpom_pkg::WIDE_W-1:0]       quotient
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [ptpom_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ptpom_pkg::DIV_W-1:0]        dsor_r, dsor_nxt;
  logic [ptpom_pkg::DIV_W-1:0]        rem_r, rem_nxt;
  logic [ptpom_pkg::WIDE_W-1:0]       quo_r, quo_nxt;
  logic [ptpom_pkg::DIV_W:0]          trial;
  logic                               fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_r, quo_r[ptpom_pkg::WIDE_W-1]};
  assign fits  = (trial >= {1'b0, dsor_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dsor_nxt = dsor_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ptpom_pkg::DIV_CNT_W'(ptpom_pkg::DIV_STEPS - 1);
      dsor_nxt = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? ptpom_pkg::DIV_W'(trial - {1'b0, dsor_r})
                     : ptpom_pkg::DIV_W'(trial);
      quo_nxt = {quo_r[ptpom_pkg::WIDE_W-2:0], fits};
      cnt_nxt = cnt_r - ptpom_pkg::DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    dsor_r <= dsor_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/ptp_offset_running_mean.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_offset_running_mean - running mean of the PTP master-to-capture offset
// Takes one PTPv2 message per transfer and returns one status transfer.
// ----------------------------------------------------------------------------
//
// Channel  Direction  tdata (low bit first)                          tuser
// in_      slave      capture_time_ns, origin_seconds,               mode
//                     origin_nanoseconds, source_identity
// out_     master     has_info, mean_offset_ns, step_mode_known,     -
//                     two_step_flag, master_valid, master_clock_id
//
// Sequence: a fold runs the bit-serial seconds multiplier, the difference, the sample,
// the span, the serial divider, the mean update and the output load, in that order. An
// origin at or beyond the seconds limit skips the multiplier and the difference; any
// other message goes straight to the output load. Stalls: in_tready is high only
// while idle; a waiting result lets the next message in, and that message's result
// holds until out_tready. Reset clears the sequencer, kept state and out_tvalid only.
// ----------------------------------------------------------------------------
module ptp_offset_running_mean (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // capture_time_ns, origin_seconds, origin_nanoseconds, source_identity
  input  logic [ptpom_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode
  input  logic [ptpom_pkg::MODE_W-1:0]         in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // has_info, mean_offset_ns, step_mode_known, two_step_flag,
  // master_valid, master_clock_id
  output logic [ptpom_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);

  // One-hot sequencer
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_DIFF = 8'b0000_0100,
    S_XVAL = 8'b0000_1000,
    S_SPAN = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Persistent state
  logic                                 seen_r, seen_nxt;
  logic                                 sync_stored_r, sync_stored_nxt;
  logic [ptpom_pkg::CAP_W-1:0]          sync_cap_r, sync_cap_nxt;
  logic [ptpom_pkg::COUNT_BITS-1:0]     count_r, count_nxt;
  logic [ptpom_pkg::MEAN_W-1:0]         mean_r, mean_nxt;
  logic [ptpom_pkg::ID_W-1:0]           gm_id_r, gm_id_nxt;
  logic                                 master_seen_r, master_seen_nxt;
  logic                                 step_known_r, step_known_nxt;
  logic                                 two_step_r, two_step_nxt;

  // Per-fold working registers
  logic [ptpom_pkg::CAP_W-1:0]          cap_r, cap_nxt;
  logic [ptpom_pkg::MAG_W-1:0]          mag_r, mag_nxt;
  logic                                 neg_r, neg_nxt;
  logic [ptpom_pkg::MEAN_W-1:0]         x_r, x_nxt;
  logic                                 ge_r, ge_nxt;

  // Output register
  logic                                 out_valid_r, out_valid_nxt;
  logic [ptpom_pkg::OUT_DATA_W-1:0]     out_data_r, out_data_nxt;

  // Input field views
  ptpom_pkg::mode_t                     in_mode;
  logic [ptpom_pkg::CAP_W-1:0]          in_cap;
  logic [ptpom_pkg::SEC_W-1:0]          in_sec;
  logic [ptpom_pkg::NSEC_W-1:0]         in_nsec;
  logic [ptpom_pkg::ID_W-1:0]           in_id;
  logic                                 in_fire;

  assign in_mode = ptpom_pkg::mode_t'(in_tuser);
  assign in_cap  = in_tdata[ptpom_pkg::IN_SEC_LO-1:ptpom_pkg::IN_CAP_LO];
  assign in_sec  = in_tdata[ptpom_pkg::IN_NSEC_LO-1:ptpom_pkg::IN_SEC_LO];
  assign in_nsec = in_tdata[ptpom_pkg::IN_ID_LO-1:ptpom_pkg::IN_NSEC_LO];
  assign in_id   = in_tdata[ptpom_pkg::IN_BITS-1:ptpom_pkg::IN_ID_LO];
  assign in_fire = in_tvalid && in_tready;

  // Units
  logic                                 mul_start, mul_done;
  logic [ptpom_pkg::WIDE_W-1:0]         origin_ns;
  logic                                 div_start, div_done;
  logic [ptpom_pkg::WIDE_W-1:0]         span, quot;
  logic [ptpom_pkg::DIV_W-1:0]          div_by;

  ptpom_mul u_mul (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (mul_start),
    .seconds     (in_sec[ptpom_pkg::MUL_BITS-1:0]),
    .nanoseconds (in_nsec),
    .done        (mul_done),
    .product     (origin_ns)
  );

  ptpom_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (span),
    .divisor  (div_by),
    .done     (div_done),
    .quotient (quot)
  );

  // Difference of capture and origin, both directions, then pick one
  logic [ptpom_pkg::WIDE_W-1:0] cap_wide, d_fwd, d_rev, d_mag;
  logic                         d_neg, d_over;

  assign cap_wide = ptpom_pkg::WIDE_W'(cap_r);
  assign d_neg    = (cap_wide < origin_ns);
  assign d_fwd    = cap_wide - origin_ns;
  assign d_rev    = origin_ns - cap_wide;
  assign d_mag    = d_neg ? d_rev : d_fwd;
  assign d_over   = (d_mag > ptpom_pkg::WIDE_W'(ptpom_pkg::DIFF_LIMIT));

  // Scale the magnitude to the fixed-point grid and clamp the positive top
  logic [ptpom_pkg::MAG_W+ptpom_pkg::FRAC_BITS-1:0] xf_scaled;
  logic [ptpom_pkg::MEAN_W-1:0]                     xf;

  assign xf_scaled = {mag_r, ptpom_pkg::FRAC_BITS'(0)};
  always_comb begin
    xf = ptpom_pkg::MEAN_W'(xf_scaled);
    if (!neg_r && xf[ptpom_pkg::MEAN_W-1]) begin
      xf = ptpom_pkg::POS_MAX;
    end
  end

  // Signed order of sample against mean, and the unsigned span between them
  logic x_ge_mean;
  assign x_ge_mean = ($signed(x_r) >= $signed(mean_r));
  assign span      = x_ge_mean ? (x_r - mean_r) : (mean_r - x_r);
  assign div_by    = ptpom_pkg::DIV_W'(count_r) + ptpom_pkg::DIV_W'(1);

  // Mean truncated toward zero
  logic [ptpom_pkg::MEAN_W-1:0] mean_shift, mean_int;
  assign mean_shift = ptpom_pkg::MEAN_W'($signed(mean_r) >>> ptpom_pkg::FRAC_BITS);
  assign mean_int   = (mean_r[ptpom_pkg::MEAN_W-1] && |(mean_r & ptpom_pkg::FRAC_MASK))
                      ? mean_shift + ptpom_pkg::MEAN_W'(1) : mean_shift;

  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    seen_nxt        = seen_r;
    sync_stored_nxt = sync_stored_r;
    sync_cap_nxt    = sync_cap_r;
    count_nxt       = count_r;
    mean_nxt        = mean_r;
    gm_id_nxt       = gm_id_r;
    master_seen_nxt = master_seen_r;
    step_known_nxt  = step_known_r;
    two_step_nxt    = two_step_r;
    cap_nxt         = cap_r;
    mag_nxt         = mag_r;
    neg_nxt         = neg_r;
    x_nxt           = x_r;
    ge_nxt          = ge_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    mul_start       = 1'b0;
    div_start       = 1'b0;

    // drop the held result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          seen_nxt  = 1'b1;
          state_nxt = S_OUT;
          unique case (in_mode)
            ptpom_pkg::MODE_SYNC: begin
              step_known_nxt = 1'b1;
              if (in_sec == '0) begin
                // two-step sync: hold the capture time for the follow-up
                sync_cap_nxt    = in_cap;
                sync_stored_nxt = 1'b1;
                two_step_nxt    = 1'b1;
              end else begin
                two_step_nxt = 1'b0;
                cap_nxt      = in_cap;
                state_nxt    = S_MUL;
              end
            end
            ptpom_pkg::MODE_FOLLOWUP: begin
              step_known_nxt = 1'b1;
              two_step_nxt   = 1'b1;
              if (sync_stored_r) begin
                cap_nxt   = sync_cap_r;
                state_nxt = S_MUL;
              end
            end
            ptpom_pkg::MODE_ANNOUNCE: begin
              gm_id_nxt       = in_id;
              master_seen_nxt = 1'b1;
            end
            ptpom_pkg::MODE_OTHER: begin
            end
            default: begin
            end
          endcase
          if (state_nxt == S_MUL) begin
            if (in_sec >= ptpom_pkg::SECONDS_LIMIT) begin
              // origin far in the future: saturate without converting
              neg_nxt   = 1'b1;
              mag_nxt   = ptpom_pkg::DIFF_LIMIT;
              state_nxt = S_XVAL;
            end else begin
              mul_start = 1'b1;
            end
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        neg_nxt   = d_neg;
        mag_nxt   = d_over ? ptpom_pkg::DIFF_LIMIT : ptpom_pkg::MAG_W'(d_mag);
        state_nxt = S_XVAL;
      end
      S_XVAL: begin
        x_nxt     = neg_r ? (ptpom_pkg::MEAN_W'(0) - xf) : xf;
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        ge_nxt    = x_ge_mean;
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        mean_nxt = ge_r ? (mean_r + quot) : (mean_r - quot);
        if (!(&count_r)) begin
          count_nxt = count_r + ptpom_pkg::COUNT_BITS'(1);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free, then load the result
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[ptpom_pkg::OUT_INFO_BIT] = seen_r;
          out_data_nxt[ptpom_pkg::OUT_KNOWN_BIT-1:ptpom_pkg::OUT_MEAN_LO] =
            mean_int[ptpom_pkg::OUT_MEAN_W-1:0];
          out_data_nxt[ptpom_pkg::OUT_KNOWN_BIT] = step_known_r;
          out_data_nxt[ptpom_pkg::OUT_TWO_BIT]   = step_known_r && two_step_r;
          out_data_nxt[ptpom_pkg::OUT_MVAL_BIT]  = master_seen_r;
          out_data_nxt[ptpom_pkg::OUT_BITS-1:ptpom_pkg::OUT_ID_LO] =
            master_seen_r ? gm_id_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      seen_r        <= 1'b0;
      sync_stored_r <= 1'b0;
      sync_cap_r    <= '0;
      count_r       <= '0;
      mean_r        <= '0;
      gm_id_r       <= '0;
      master_seen_r <= 1'b0;
      step_known_r  <= 1'b0;
      two_step_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      seen_r        <= seen_nxt;
      sync_stored_r <= sync_stored_nxt;
      sync_cap_r    <= sync_cap_nxt;
      count_r       <= count_nxt;
      mean_r        <= mean_nxt;
      gm_id_r       <= gm_id_nxt;
      master_seen_r <= master_seen_nxt;
      step_known_r  <= step_known_nxt;
      two_step_r    <= two_step_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cap_r      <= cap_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    x_r        <= x_nxt;
    ge_r       <= ge_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/ptpom_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpom_checker - port-level checks of the PTP offset running mean
// Watches both stream channels and the result fields over time.
// ----------------------------------------------------------------------------
module ptpom_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic [ptpom_pkg::IN_DATA_W-1:0]      in_tdata,
  input logic [ptpom_pkg::MODE_W-1:0]         in_tuser,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic [ptpom_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic                                 out_tvalid,
  input logic                                 out_tready
);

  // a stalled result transfer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // every result follows a message, so has_info is always set
  a_has_info: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ptpom_pkg::OUT_INFO_BIT])
    else $error("result without has_info");

  // no master identity shows before an announce
  a_id_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[ptpom_pkg::OUT_MVAL_BIT]
      |-> out_tdata[ptpom_pkg::OUT_BITS-1:ptpom_pkg::OUT_ID_LO] == '0)
    else $error("master identity without announce");

  // one message in work at a time: no back-to-back input transfers
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second message taken while one is in work");

endmodule

bind ptp_offset_running_mean ptpom_checker u_ptpom_checker (.*);

/* tb/sv/tb_ptp_offset_running_mean.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ptp_offset_running_mean - self-checking bench for the PTP offset mean
// Streams PTPv2 messages into the block and checks every status transfer
// against a bit-exact prediction of the Q48.16 running mean. It runs a directed
// set of corner cases, then random two-step pairs, one-step syncs, announces
// and noise, with random idle bursts on both channels and one long hold-off.
// ----------------------------------------------------------------------------
module tb_ptp_offset_running_mean;
  import ptpom_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CALM_TAIL    = 150;    // last messages sent with no idling
  localparam int HOLD_AFTER   = 200;    // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 600;
  localparam int END_DRAIN    = 120;    // quiet spell after the last status

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] COUNT_TOP = (64'd1 << COUNT_BITS) - 64'd1;

  typedef struct {
    mode_t             mode;
    logic [CAP_W-1:0]  cap;
    logic [SEC_W-1:0]  sec;
    logic [NSEC_W-1:0] nsec;
    logic [ID_W-1:0]   id;
  } ptp_msg_t;

  typedef struct {
    logic                  info;
    logic [OUT_MEAN_W-1:0] mean;
    logic                  known;
    logic                  two_step;
    logic                  mval;
    logic [ID_W-1:0]       gm_id;
  } status_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [MODE_W-1:0]     in_tuser   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ptp_offset_running_mean DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),   // capture_time_ns, origin_seconds,
                              // origin_nanoseconds, source_identity
    .in_tuser   (in_tuser),   // mode
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),  // has_info, mean_offset_ns, step_mode_known,
                              // two_step_flag, master_valid, master_clock_id
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  ptp_msg_t pending_msgs[$];      // messages still to be offered
  status_t  expected_status[$];   // one status per accepted message, oldest first

  int   total_items  = 0;
  int   accepted     = 0;
  int   results_seen = 0;
  int   mismatches   = 0;
  int   kind_count[4] = '{0, 0, 0, 0};
  int   fold_count   = 0;
  int   sat_count    = 0;
  logic calm         = 1'b0;      // no idling once the tail of the run is reached
  logic hold_off     = 1'b0;      // long receiver hold-off

  // Predicted block state
  logic             seen_any    = 1'b0;
  logic             sync_stored = 1'b0;
  logic [CAP_W-1:0] sync_cap    = '0;
  logic [63:0]      sample_n    = '0;
  logic [63:0]      mean_fixed  = '0;
  logic [ID_W-1:0]  gm_id       = '0;
  logic             master_seen = 1'b0;
  logic             step_known  = 1'b0;
  logic             two_step    = 1'b0;

  // --------------------------------------------------------------------------
  // Running-mean predictor
  // --------------------------------------------------------------------------

  // Fold one capture-minus-origin sample into the Q48.16 mean.
  function automatic void fold_offset_sample(logic [CAP_W-1:0] cap,
                                             logic [SEC_W-1:0] sec,
                                             logic [NSEC_W-1:0] nsec);
    logic [63:0] origin, mag, xf, x, span, div;
    logic        neg;
    fold_count++;
    if (sec >= SECONDS_LIMIT) begin
      // an origin this far out is always beyond any capture
      neg = 1'b1;
      mag = 64'(DIFF_LIMIT);
      sat_count++;
    end else begin
      origin = 64'(sec) * NS_PER_S + 64'(nsec);
      if (64'(cap) >= origin) begin
        neg = 1'b0;
        mag = 64'(cap) - origin;
      end else begin
        neg = 1'b1;
        mag = origin - 64'(cap);
      end
      if (mag > 64'(DIFF_LIMIT)) begin
        mag = 64'(DIFF_LIMIT);
        sat_count++;
      end
    end
    xf = mag << FRAC_BITS;
    if (!neg && xf > 64'(POS_MAX)) xf = 64'(POS_MAX);
    x   = neg ? (64'd0 - xf) : xf;
    div = sample_n + 64'd1;
    // signed compare via offset binary, then move the mean towards x
    if ((x ^ SIGN_BIT) >= (mean_fixed ^ SIGN_BIT)) begin
      span       = x - mean_fixed;
      mean_fixed = mean_fixed + span / div;
    end else begin
      span       = mean_fixed - x;
      mean_fixed = mean_fixed - span / div;
    end
    if (sample_n < COUNT_TOP) sample_n = sample_n + 64'd1;
  endfunction

  // Advance the predicted state by one message and return its status.
  function automatic status_t advance_offset_mean(ptp_msg_t m);
    status_t     s;
    logic [63:0] whole;
    kind_count[int'(m.mode)]++;
    seen_any = 1'b1;
    case (m.mode)
      MODE_SYNC: begin
        step_known = 1'b1;
        if (m.sec == '0) begin
          sync_cap    = m.cap;
          sync_stored = 1'b1;
          two_step    = 1'b1;
        end else begin
          fold_offset_sample(m.cap, m.sec, m.nsec);
          two_step = 1'b0;
        end
      end
      MODE_FOLLOWUP: begin
        step_known = 1'b1;
        two_step   = 1'b1;
        if (sync_stored) fold_offset_sample(sync_cap, m.sec, m.nsec);
      end
      MODE_ANNOUNCE: begin
        gm_id       = m.id;
        master_seen = 1'b1;
      end
      default: ;
    endcase
    // truncate towards zero
    if (mean_fixed[63]) begin
      whole = (64'd0 - mean_fixed) >> FRAC_BITS;
      whole = 64'd0 - whole;
    end else begin
      whole = mean_fixed >> FRAC_BITS;
    end
    s.info     = seen_any;
    s.mean     = whole[OUT_MEAN_W-1:0];
    s.known    = step_known;
    s.two_step = step_known & two_step;
    s.mval     = master_seen;
    s.gm_id    = master_seen ? gm_id : '0;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Build a message whose origin lies the given offset before the capture.
  function automatic ptp_msg_t timed_msg(mode_t kind, logic [CAP_W-1:0] cap,
                                         longint offset);
    ptp_msg_t    m;
    logic [63:0] origin;
    origin = 64'(cap) - 64'(offset);
    m.mode = kind;
    m.cap  = cap;
    m.sec  = SEC_W'(origin / NS_PER_S);
    m.nsec = NSEC_W'(origin % NS_PER_S);
    m.id   = {$urandom, $urandom};
    return m;
  endfunction

  // Capture time far enough from both ends that any offset keeps the origin legal.
  function automatic logic [CAP_W-1:0] random_capture();
    logic [CAP_W-1:0] c;
    c = CAP_W'({$urandom, $urandom});
    if (c < (CAP_W'(1) << 52)) c = c + (CAP_W'(1) << 52);
    if (c > ({CAP_W{1'b1}} - (CAP_W'(1) << 52))) c = c - (CAP_W'(1) << 52);
    return c;
  endfunction

  // Offsets from zero up to beyond the saturation limit, either sign.
  function automatic longint random_offset();
    logic [63:0] mag;
    case ($urandom_range(0, 3))
      0:       mag = 64'($urandom_range(0, 2000));
      1:       mag = 64'($urandom);
      2:       mag = {$urandom, $urandom} >> 17;
      default: mag = {$urandom, $urandom} >> 14;
    endcase
    return $urandom_range(0, 1) ? longint'(mag) : -longint'(mag);
  endfunction

  function automatic ptp_msg_t raw_msg(mode_t kind, logic [CAP_W-1:0] cap,
                                       logic [SEC_W-1:0] sec, logic [NSEC_W-1:0] nsec,
                                       logic [ID_W-1:0] id);
    ptp_msg_t m;
    m.mode = kind;
    m.cap  = cap;
    m.sec  = sec;
    m.nsec = nsec;
    m.id   = id;
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued messages, with random idle bursts
  // --------------------------------------------------------------------------
  ptp_msg_t tx_msg;
  int       tx_gap = 0;

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      // predict on the transfer, before the slot is refilled
      if (in_tvalid && in_tready) begin
        expected_status.push_back(advance_offset_mean(tx_msg));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(0, 17);
          in_tvalid <= 1'b0;
        end else if (pending_msgs.size() != 0) begin
          tx_msg = pending_msgs.pop_front();
          in_tdata  <= IN_DATA_W'({tx_msg.id, tx_msg.nsec, tx_msg.sec, tx_msg.cap});
          in_tuser  <= tx_msg.mode;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      calm <= (pending_msgs.size() < CALM_TAIL);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall at random, check every status transfer
  // --------------------------------------------------------------------------
  int rx_stall = 0;

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s at result %0d: expected %h, got %h",
               field, results_seen, want, got);
  endtask

  always @(posedge clk) begin : monitor
    status_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.info     = out_tdata[OUT_INFO_BIT];
        got.mean     = out_tdata[OUT_MEAN_LO +: OUT_MEAN_W];
        got.known    = out_tdata[OUT_KNOWN_BIT];
        got.two_step = out_tdata[OUT_TWO_BIT];
        got.mval     = out_tdata[OUT_MVAL_BIT];
        got.gm_id    = out_tdata[OUT_ID_LO +: ID_W];
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected status transfer %0d: %h", results_seen, out_tdata);
        end else begin
          want = expected_status.pop_front();
          if (got.info !== want.info) note_mismatch("has_info", 64'(want.info), 64'(got.info));
          if (got.mean !== want.mean) note_mismatch("mean_offset_ns", 64'(want.mean), 64'(got.mean));
          if (got.known !== want.known)
            note_mismatch("step_mode_known", 64'(want.known), 64'(got.known));
          if (got.two_step !== want.two_step)
            note_mismatch("two_step_flag", 64'(want.two_step), 64'(got.two_step));
          if (got.mval !== want.mval)
            note_mismatch("master_valid", 64'(want.mval), 64'(got.mval));
          if (got.gm_id !== want.gm_id)
            note_mismatch("master_clock_id", want.gm_id, got.gm_id);
        end
        results_seen++;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(0, 17);
        out_tready <= 1'b0;
      end else begin
        out_tready <= !hold_off;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off: block the result side while messages keep coming
  // --------------------------------------------------------------------------
  initial begin : receiver_hold
    wait (results_seen >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CAP_W-1:0] cap, last_two_cap;
    int               pick, directed;
    mode_t            kind;

    // Directed corner cases
    // follow-up with no sync stored, then plain info and an all-zero announce
    pending_msgs.push_back(raw_msg(MODE_FOLLOWUP, 63'd12345, 48'd5, 30'd7, 64'd0));
    pending_msgs.push_back(raw_msg(MODE_OTHER, '0, '0, '0, '0));
    pending_msgs.push_back(raw_msg(MODE_ANNOUNCE, '0, '0, '0, 64'd0));
    // one-step syncs: negative, huge positive (clamped), huge origin seconds
    pending_msgs.push_back(raw_msg(MODE_SYNC, 63'd0, 48'd1, 30'd0, '0));
    pending_msgs.push_back(raw_msg(MODE_SYNC, {CAP_W{1'b1}}, 48'd1, 30'd0, '0));
    pending_msgs.push_back(raw_msg(MODE_SYNC, 63'd0, {SEC_W{1'b1}}, {NSEC_W{1'b1}}, '0));
    // seconds just under and at the limit, nanoseconds out of range
    pending_msgs.push_back(raw_msg(MODE_SYNC, 63'd1000, SECONDS_LIMIT - 48'd1,
                                   {NSEC_W{1'b1}}, '0));
    pending_msgs.push_back(raw_msg(MODE_SYNC, {CAP_W{1'b1}}, SECONDS_LIMIT, 30'd0, '0));
    // zero difference and the saturation boundaries
    pending_msgs.push_back(raw_msg(MODE_SYNC, 63'd5_000_000_123, 48'd5, 30'd123, '0));
    pending_msgs.push_back(timed_msg(MODE_SYNC, (63'd1 << 47) + 63'd2_000_000_000,
                                     longint'(64'd1 << 47)));
    pending_msgs.push_back(timed_msg(MODE_SYNC, (63'd1 << 47) + 63'd2_000_000_000,
                                     longint'(64'd1 << 47) + 1));
    pending_msgs.push_back(timed_msg(MODE_SYNC, 63'd1_000_000_000,
                                     -longint'(64'd1 << 47)));
    pending_msgs.push_back(timed_msg(MODE_SYNC, 63'd1_000_000_000,
                                     -longint'(64'd1 << 47) - 1));
    // two-step sync, then reuse its stored capture across a one-step sync
    pending_msgs.push_back(raw_msg(MODE_SYNC, 63'd1 << 62, '0, 30'd999_999_999, '0));
    pending_msgs.push_back(timed_msg(MODE_FOLLOWUP, 63'd1 << 62, 64'sd12345));
    pending_msgs.push_back(timed_msg(MODE_FOLLOWUP, 63'd1 << 62, -64'sd777));
    pending_msgs.push_back(timed_msg(MODE_SYNC, random_capture(), 64'sd50));
    pending_msgs.push_back(timed_msg(MODE_FOLLOWUP, 63'd1 << 62, 64'sd3));
    pending_msgs.push_back(raw_msg(MODE_FOLLOWUP, '0, '0, '0, '0));
    pending_msgs.push_back(raw_msg(MODE_FOLLOWUP, '0, {SEC_W{1'b1}}, {NSEC_W{1'b1}}, '0));
    // two-step pair with a zero difference
    pending_msgs.push_back(raw_msg(MODE_SYNC, '0, '0, '0, '0));
    pending_msgs.push_back(raw_msg(MODE_FOLLOWUP, '0, '0, '0, '0));
    // all-ones identity, and an ignored kind with every field set
    pending_msgs.push_back(raw_msg(MODE_ANNOUNCE, '0, '0, '0, {ID_W{1'b1}}));
    pending_msgs.push_back(raw_msg(MODE_OTHER, {CAP_W{1'b1}}, {SEC_W{1'b1}},
                                   {NSEC_W{1'b1}}, {ID_W{1'b1}}));
    directed     = pending_msgs.size();
    last_two_cap = '0;

    // Random part: mostly well-formed traffic, the rest noise
    while (pending_msgs.size() < directed + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      cap  = random_capture();
      if (pick < 35) begin
        pending_msgs.push_back(raw_msg(MODE_SYNC, cap, '0, NSEC_W'($urandom),
                                       {$urandom, $urandom}));
        last_two_cap = cap;
        pending_msgs.push_back(timed_msg(MODE_FOLLOWUP, cap, random_offset()));
      end else if (pick < 60) begin
        pending_msgs.push_back(timed_msg(MODE_SYNC, cap, random_offset()));
      end else if (pick < 68) begin
        pending_msgs.push_back(timed_msg(MODE_FOLLOWUP, last_two_cap, random_offset()));
      end else if (pick < 76) begin
        pending_msgs.push_back(raw_msg(MODE_ANNOUNCE, cap, SEC_W'({$urandom, $urandom}),
                                       NSEC_W'($urandom), {$urandom, $urandom}));
      end else if (pick < 82) begin
        pending_msgs.push_back(raw_msg(MODE_OTHER, CAP_W'({$urandom, $urandom}),
                                       SEC_W'({$urandom, $urandom}), NSEC_W'($urandom),
                                       {$urandom, $urandom}));
      end else begin
        // noise: any kind, any field, seconds raw, legal-looking or zero
        kind = mode_t'(MODE_W'($urandom_range(0, 3)));
        case ($urandom_range(0, 3))
          0:       pending_msgs.push_back(raw_msg(kind, CAP_W'({$urandom, $urandom}), '0,
                                                  NSEC_W'($urandom), {$urandom, $urandom}));
          1:       pending_msgs.push_back(raw_msg(kind, CAP_W'({$urandom, $urandom}),
                                                  SEC_W'({$urandom, $urandom} % SECONDS_LIMIT),
                                                  NSEC_W'($urandom), {$urandom, $urandom}));
          default: pending_msgs.push_back(raw_msg(kind, CAP_W'({$urandom, $urandom}),
                                                  SEC_W'({$urandom, $urandom}),
                                                  NSEC_W'($urandom), {$urandom, $urandom}));
        endcase
      end
    end
    total_items = pending_msgs.size();

    // Release reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every message accepted, every status returned, then a quiet spell
    while (accepted < total_items) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);

    $display("Ran %0d messages: %0d sync, %0d follow-up, %0d announce, %0d other.",
             total_items, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("Checked %0d status transfers; %0d samples folded, %0d saturated.",
             results_seen, fold_count, sat_count);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
